[sv/vwir_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex weld package
// Shared constants, request codes and types of the vertex weld and index
// remap block.
// ----------------------------------------------------------------------------
package vwir_pkg;

	// Capacity of the vertex store and the derived index and count widths.
	localparam int MAX_VERTS        = 256;
	localparam int IDX_W            = $clog2(MAX_VERTS);
	localparam int CNT_W            = IDX_W + 1;

	// Vertex layout: six raw 64-bit words.
	localparam int WORD_W           = 64;
	localparam int WORDS_PER_VERTEX = 6;
	localparam int VERT_W           = WORD_W * WORDS_PER_VERTEX;

	// One distinct-store entry holds the vertex and its representative index.
	localparam int DIST_W           = VERT_W + IDX_W;

	// Field widths of the channels.
	localparam int REQ_W            = 2;
	localparam int INDEX_W          = 32;
	localparam int DCOUNT_W         = 9;

	// Request codes.
	localparam logic [REQ_W-1:0] REQ_VERTEX = 2'd0;
	localparam logic [REQ_W-1:0] REQ_CORNER = 2'd1;
	localparam logic [REQ_W-1:0] REQ_CLEAR  = 2'd2;

	// Mapped index reported for a vertex that did not fit.
	localparam logic [INDEX_W-1:0] INDEX_NONE = '1;

	// One result item.
	typedef struct packed {
		logic signed [INDEX_W-1:0] mapped_index;
		logic                      is_new;
		logic [DCOUNT_W-1:0]       distinct_count;
		logic                      store_full;
	} res_t;

	// Occupancy of the current mesh.
	typedef struct packed {
		logic [CNT_W-1:0] vcount;
		logic [CNT_W-1:0] dtotal;
	} stat_t;

endpackage

[sv/vwir_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex weld channels
// Request and response channels with a valid/ready handshake; a transfer
// happens at a rising edge with valid and ready both high.
// ----------------------------------------------------------------------------
interface vwir_req_if;
	logic                                  valid;
	logic                                  ready;
	logic [vwir_pkg::REQ_W-1:0]            req_type;
	logic [vwir_pkg::WORD_W-1:0]           word0;
	logic [vwir_pkg::WORD_W-1:0]           word1;
	logic [vwir_pkg::WORD_W-1:0]           word2;
	logic [vwir_pkg::WORD_W-1:0]           word3;
	logic [vwir_pkg::WORD_W-1:0]           word4;
	logic [vwir_pkg::WORD_W-1:0]           word5;
	logic signed [vwir_pkg::INDEX_W-1:0]   corner_index;

	modport source (
		output valid, req_type, word0, word1, word2, word3, word4, word5, corner_index,
		input  ready
	);
	modport sink (
		input  valid, req_type, word0, word1, word2, word3, word4, word5, corner_index,
		output ready
	);
endinterface

interface vwir_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [vwir_pkg::INDEX_W-1:0]   mapped_index;
	logic                                  is_new;
	logic [vwir_pkg::DCOUNT_W-1:0]         distinct_count;
	logic                                  store_full;

	modport source (
		output valid, mapped_index, is_new, distinct_count, store_full,
		input  ready
	);
	modport sink (
		input  valid, mapped_index, is_new, distinct_count, store_full,
		output ready
	);
endinterface

[sv/vwir_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex weld RAM
// Simple dual-port synchronous RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module vwir_ram #(
	parameter int WIDTH = 8,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	localparam int DEPTH = 1 << AW;

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/vwir_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex weld controller
// Sequencer that scans the distinct-vertex store one entry per cycle,
// records the representative of each vertex and looks up corner indices.
// ----------------------------------------------------------------------------
module vwir_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	vwir_req_if.sink        req,
	output vwir_pkg::res_t  res,
	output logic            res_valid,
	input  logic            res_ready,
	output vwir_pkg::stat_t stat
);

	import vwir_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MAP_RD,
		ST_EMIT
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   vcount_q;
	logic [CNT_W-1:0]   dtotal_q;
	logic [CNT_W-1:0]   issue_q;
	logic               chk_s1;
	logic [VERT_W-1:0]  vert_q;
	res_t               res_q;

	logic               accept;
	logic [VERT_W-1:0]  req_vert;
	logic [INDEX_W-1:0] corner_raw;
	logic               full;
	logic               corner_hit;

	logic               dist_re;
	logic [IDX_W-1:0]   dist_raddr;
	logic [DIST_W-1:0]  dist_rdata;
	logic               dist_we;
	logic [IDX_W-1:0]   dist_waddr;
	logic [DIST_W-1:0]  dist_wdata;
	logic               map_re;
	logic [IDX_W-1:0]   map_raddr;
	logic [IDX_W-1:0]   map_rdata;
	logic               map_we;
	logic [IDX_W-1:0]   map_waddr;
	logic [IDX_W-1:0]   map_wdata;

	logic               hit;
	logic               miss_done;
	logic               scan_done;
	logic [IDX_W-1:0]   rep;
	logic [CNT_W-1:0]   dtotal_next;

	// Request side decode.
	assign req.ready  = (state_q == ST_IDLE);
	assign accept     = req.valid && req.ready;
	assign req_vert   = {req.word5, req.word4, req.word3, req.word2, req.word1, req.word0};
	assign corner_raw = req.corner_index;
	assign full       = (vcount_q >= CNT_W'(MAX_VERTS));
	assign corner_hit = !corner_raw[INDEX_W-1] && (corner_raw < INDEX_W'(vcount_q));

	// Scan: one store read is issued per cycle and checked the cycle after.
	assign dist_re    = (state_q == ST_SCAN) && (issue_q < dtotal_q);
	assign dist_raddr = issue_q[IDX_W-1:0];
	assign hit        = chk_s1 && (dist_rdata[DIST_W-1:IDX_W] == vert_q);
	assign miss_done  = (state_q == ST_SCAN) && !chk_s1 && (issue_q == dtotal_q);
	assign scan_done  = (state_q == ST_SCAN) && (hit || miss_done);
	assign rep        = hit ? dist_rdata[IDX_W-1:0] : vcount_q[IDX_W-1:0];
	assign dtotal_next = hit ? dtotal_q : dtotal_q + CNT_W'(1);

	// Write back at the end of a scan: the map always, the store on a miss.
	// Reads and writes never meet at one entry, since the sequencer runs one
	// item at a time and a new entry lies above every address being read.
	assign map_we     = scan_done;
	assign map_waddr  = vcount_q[IDX_W-1:0];
	assign map_wdata  = rep;
	assign dist_we    = scan_done && !hit;
	assign dist_waddr = dtotal_q[IDX_W-1:0];
	assign dist_wdata = {vert_q, vcount_q[IDX_W-1:0]};

	// Corner lookup is issued as the request transfers.
	assign map_re     = accept && (req.req_type == REQ_CORNER) && corner_hit;
	assign map_raddr  = corner_raw[IDX_W-1:0];

	vwir_ram #(
		.WIDTH (DIST_W),
		.AW    (IDX_W)
	) u_dist_ram (
		.clk   (clk),
		.we    (dist_we),
		.waddr (dist_waddr),
		.wdata (dist_wdata),
		.re    (dist_re),
		.raddr (dist_raddr),
		.rdata (dist_rdata)
	);

	vwir_ram #(
		.WIDTH (IDX_W),
		.AW    (IDX_W)
	) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.re    (map_re),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	// Captured vertex under comparison.
	always_ff @(posedge clk) begin
		if (accept) begin
			vert_q <= req_vert;
		end
	end

	// Sequencer with counts and the registered result.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			vcount_q <= '0;
			dtotal_q <= '0;
			issue_q  <= '0;
			chk_s1   <= 1'b0;
			res_q    <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (req.req_type)
							REQ_VERTEX: begin
								if (full) begin
									res_q.mapped_index   <= INDEX_NONE;
									res_q.is_new         <= 1'b0;
									res_q.distinct_count <= DCOUNT_W'(dtotal_q);
									res_q.store_full     <= 1'b1;
									state_q              <= ST_EMIT;
								end else begin
									issue_q <= '0;
									chk_s1  <= 1'b0;
									state_q <= ST_SCAN;
								end
							end
							REQ_CORNER: begin
								if (corner_hit) begin
									state_q <= ST_MAP_RD;
								end else begin
									res_q.mapped_index   <= req.corner_index;
									res_q.is_new         <= 1'b0;
									res_q.distinct_count <= DCOUNT_W'(dtotal_q);
									res_q.store_full     <= 1'b0;
									state_q              <= ST_EMIT;
								end
							end
							REQ_CLEAR: begin
								vcount_q <= '0;
								dtotal_q <= '0;
								res_q    <= '0;
								state_q  <= ST_EMIT;
							end
							default: begin
								res_q.mapped_index   <= '0;
								res_q.is_new         <= 1'b0;
								res_q.distinct_count <= DCOUNT_W'(dtotal_q);
								res_q.store_full     <= 1'b0;
								state_q              <= ST_EMIT;
							end
						endcase
					end
				end
				ST_SCAN: begin
					chk_s1 <= dist_re;
					if (dist_re) begin
						issue_q <= issue_q + CNT_W'(1);
					end
					if (scan_done) begin
						vcount_q             <= vcount_q + CNT_W'(1);
						dtotal_q             <= dtotal_next;
						res_q.mapped_index   <= INDEX_W'(rep);
						res_q.is_new         <= !hit;
						res_q.distinct_count <= DCOUNT_W'(dtotal_next);
						res_q.store_full     <= 1'b0;
						state_q              <= ST_EMIT;
					end
				end
				ST_MAP_RD: begin
					res_q.mapped_index   <= INDEX_W'(map_rdata);
					res_q.is_new         <= 1'b0;
					res_q.distinct_count <= DCOUNT_W'(dtotal_q);
					res_q.store_full     <= 1'b0;
					state_q              <= ST_EMIT;
				end
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res         = res_q;
	assign res_valid   = (state_q == ST_EMIT);
	assign stat.vcount = vcount_q;
	assign stat.dtotal = dtotal_q;

endmodule

[sv/vertex_weld_index_remap_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex weld and index remap
// Welds bitwise-identical vertices of a mesh and remaps triangle corner
// indices onto one representative per set of equal vertices.
// ----------------------------------------------------------------------------
// Usage:
//   req carries vertex, corner and clear requests; rsp returns exactly one
//   result per request, in order. Both use valid/ready transfers.
//   A vertex is compared against the distinct vertices of the mesh, one
//   store entry per cycle from a 392-bit wide RAM; a match ends the scan
//   early. A corner request inside the mesh reads the vertex map RAM;
//   other corners, clear, unused codes and vertices refused by a full
//   store are answered without a RAM read. The result passes from the
//   sequencer's result register to the output register; requests are
//   worked one at a time.
//   The output register lets the next request be taken while a result
//   waits. If rsp stays stalled, the sequencer holds its next result and
//   req.ready stays low until the output register frees up.
//   Reset empties the mesh (both counts zero); the RAMs are not cleared and
//   need no clearing, since only entries below the counts are ever read.
//   Once 256 vertices are stored, further vertices return index -1 with
//   store_full set until a clear request.
// ----------------------------------------------------------------------------
module vertex_weld_index_remap_top (
	input  logic      clk,
	input  logic      arst_n,
	vwir_req_if.sink  req,
	vwir_rsp_if.source rsp
);

	import vwir_pkg::*;

	res_t  res;
	logic  res_valid;
	logic  res_ready;
	stat_t stat;
	logic  rsp_valid_q;
	res_t  rsp_q;
	logic  load;

	vwir_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.stat      (stat)
	);

	// Output register: refilled when empty or when its result transfers.
	assign res_ready = !rsp_valid_q || rsp.ready;
	assign load      = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.mapped_index   = rsp_q.mapped_index;
	assign rsp.is_new         = rsp_q.is_new;
	assign rsp.distinct_count = rsp_q.distinct_count;
	assign rsp.store_full     = rsp_q.store_full;

	// A mesh never has more distinct vertices than vertices.
	a_dtotal_le_vcount: assert property (@(posedge clk) disable iff (!arst_n)
		stat.dtotal <= stat.vcount)
		else $error("distinct count exceeds vertex count");

	// The vertex count never runs past the store capacity.
	a_vcount_cap: assert property (@(posedge clk) disable iff (!arst_n)
		stat.vcount <= CNT_W'(MAX_VERTS))
		else $error("vertex count exceeds capacity");

	// A rejected vertex is never new and always reports index -1.
	a_full_result: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.store_full |-> !rsp.is_new && (rsp.mapped_index == INDEX_NONE))
		else $error("store-full result carries a valid index");

	// The sequencer works one request at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("request taken while busy");

endmodule

[tb/vertex_weld_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex weld checker
// Watches the request and result channels of the vertex weld block. It keeps
// its own copy of the distinct-vertex store and the vertex map, works out the
// result of every accepted request, and compares each result transfer field
// by field with the oldest prediction still due.
// ----------------------------------------------------------------------------
module vertex_weld_checker (
	input  logic clk,
	input  logic arst_n,
	vwir_req_if  req,
	vwir_rsp_if  rsp,
	output int   weld_errors,
	output int   results_due
);

	import vwir_pkg::*;

	// Shadow copy of the mesh: distinct vertices, the first vertex index of
	// each, and the representative of every vertex taken so far.
	logic [VERT_W-1:0] uniq_vert  [MAX_VERTS];
	logic [IDX_W-1:0]  uniq_first [MAX_VERTS];
	logic [IDX_W-1:0]  vert_rep   [MAX_VERTS];
	logic [CNT_W-1:0]  vert_total;
	logic [CNT_W-1:0]  uniq_total;

	// Results predicted for accepted requests, oldest first.
	res_t weld_results_due [$];
	res_t got;
	res_t want;

	// Works out the result of one request and updates the shadow mesh.
	function automatic res_t weld_predict(input logic [REQ_W-1:0] kind,
			input logic [VERT_W-1:0] vert, input logic signed [INDEX_W-1:0] corner);
		res_t             r;
		logic [IDX_W-1:0] rep;
		logic             hit;
		int               d;
		r = '0;
		r.distinct_count = DCOUNT_W'(uniq_total);
		case (kind)
			REQ_VERTEX: begin
				if (vert_total >= MAX_VERTS) begin
					// The store is full: nothing is compared or stored.
					r.mapped_index = INDEX_NONE;
					r.store_full   = 1'b1;
				end else begin
					hit = 1'b0;
					rep = vert_total[IDX_W-1:0];
					for (d = 0; d < MAX_VERTS; d++) begin
						if (!hit && d < uniq_total && uniq_vert[d] == vert) begin
							hit = 1'b1;
							rep = uniq_first[d];
						end
					end
					if (!hit) begin
						uniq_vert[uniq_total[IDX_W-1:0]]  = vert;
						uniq_first[uniq_total[IDX_W-1:0]] = vert_total[IDX_W-1:0];
						uniq_total = uniq_total + 1'b1;
					end
					vert_rep[vert_total[IDX_W-1:0]] = rep;
					vert_total = vert_total + 1'b1;
					r.mapped_index   = {{(INDEX_W-IDX_W){1'b0}}, rep};
					r.is_new         = !hit;
					r.distinct_count = DCOUNT_W'(uniq_total);
				end
			end
			REQ_CORNER: begin
				// Only a non-negative index below the vertex count is remapped.
				r.mapped_index = corner;
				if (!corner[INDEX_W-1] && corner[INDEX_W-2:0] < vert_total)
					r.mapped_index = {{(INDEX_W-IDX_W){1'b0}}, vert_rep[corner[IDX_W-1:0]]};
			end
			REQ_CLEAR: begin
				vert_total = '0;
				uniq_total = '0;
				r          = '0;
			end
			default: begin
				// The unused code only reports the distinct count.
			end
		endcase
		return r;
	endfunction

	// Reports one field that differs from its prediction.
	task automatic check_field(input string name, input logic signed [63:0] want_v,
			input logic signed [63:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want_v, got_v);
			weld_errors++;
		end
	endtask

	// A result transfer is checked before a request transfer of the same edge
	// is predicted, since it can only belong to an earlier request.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vert_total  = '0;
			uniq_total  = '0;
			weld_results_due.delete();
			results_due = 0;
			weld_errors = 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				got.mapped_index   = rsp.mapped_index;
				got.is_new         = rsp.is_new;
				got.distinct_count = rsp.distinct_count;
				got.store_full     = rsp.store_full;
				if (weld_results_due.size() == 0) begin
					$display("%0t: unrequested result, expected none, actual index %0d",
						$time, got.mapped_index);
					weld_errors++;
				end else begin
					want = weld_results_due.pop_front();
					check_field("mapped_index", want.mapped_index, got.mapped_index);
					check_field("is_new", want.is_new, got.is_new);
					check_field("distinct_count", want.distinct_count, got.distinct_count);
					check_field("store_full", want.store_full, got.store_full);
				end
			end
			if (req.valid && req.ready)
				weld_results_due.push_back(weld_predict(req.req_type,
					{req.word5, req.word4, req.word3, req.word2, req.word1, req.word0},
					req.corner_index));
			results_due = weld_results_due.size();
		end
	end

endmodule

[tb/vertex_weld_index_remap_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex weld testbench
// Drives meshes of vertex, corner and clear requests into the vertex weld
// block, with random gaps on both channels, and leaves all checking to the
// vertex weld checker beside the block. A short directed part covers the
// corner and code extremes; the random part builds meshes from small vertex
// pools, fills the store past its capacity and mixes in noise.
// ----------------------------------------------------------------------------
module vertex_weld_index_remap_top_tb;
	import vwir_pkg::*;

	localparam int RANDOM_ITEMS = 1350;
	localparam int POOL_MAX     = 48;
	localparam int DRAIN_CYCLES = 300;
	localparam int LIMIT_CYCLES = 1_500_000;

	localparam logic [REQ_W-1:0]          REQ_UNUSED    = 2'd3;
	localparam logic signed [INDEX_W-1:0] INDEX_MAX_POS = 32'sh7fff_ffff;
	localparam logic signed [INDEX_W-1:0] INDEX_MIN_NEG = 32'sh8000_0000;
	localparam logic [VERT_W-1:0]         VERT_ZERO     = '0;
	localparam logic [VERT_W-1:0]         VERT_ONES     = '1;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   rsp_idle_pct;
	int   items_sent;
	int   mesh_verts;
	int   pool_n;
	int   weld_errors;
	int   results_due;
	int   cycle_count;

	logic [VERT_W-1:0] pool [POOL_MAX];

	vwir_req_if req_ch ();
	vwir_rsp_if rsp_ch ();

	vertex_weld_index_remap_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	vertex_weld_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.weld_errors (weld_errors),
		.results_due (results_due)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// The result side stalls at random.
	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
	end

	// Run limit.
	initial begin
		cycle_count = 0;
		while (cycle_count < LIMIT_CYCLES) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	// Random vertex: mostly random bits, now and then all zeros or all ones.
	function automatic logic [VERT_W-1:0] rand_vertex();
		logic [VERT_W-1:0] v;
		int                k;
		int                sel;
		sel = $urandom_range(0, 99);
		for (k = 0; k < VERT_W / 32; k++)
			v[k*32 +: 32] = $urandom;
		if (sel < 2)
			v = VERT_ZERO;
		else if (sel < 4)
			v = VERT_ONES;
		return v;
	endfunction

	// Corner index: mostly inside the mesh, otherwise at or past its edge, negative or random.
	function automatic logic signed [INDEX_W-1:0] pick_corner(input int verts);
		int sel;
		sel = $urandom_range(0, 99);
		if (verts > 0 && sel < 80)
			return $urandom_range(0, verts - 1);
		else if (sel % 6 == 0)
			return verts;
		else if (sel % 6 == 1)
			return verts + $urandom_range(1, 3);
		else if (sel % 6 == 2)
			return -1;
		else if (sel % 6 == 3)
			return {1'b1, 31'($urandom)};
		else if (sel % 6 == 4)
			return $urandom_range(0, 1) ? INDEX_MAX_POS : INDEX_MIN_NEG;
		return $urandom;
	endfunction

	// One request transfer, after a random number of idle cycles. It starts
	// and ends at a falling edge and leaves valid high for the next call.
	task automatic send_req(input logic [REQ_W-1:0] kind, input logic [VERT_W-1:0] vert,
			input logic signed [INDEX_W-1:0] corner);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid        <= 1'b1;
		req_ch.req_type     <= kind;
		req_ch.word0        <= vert[0*WORD_W +: WORD_W];
		req_ch.word1        <= vert[1*WORD_W +: WORD_W];
		req_ch.word2        <= vert[2*WORD_W +: WORD_W];
		req_ch.word3        <= vert[3*WORD_W +: WORD_W];
		req_ch.word4        <= vert[4*WORD_W +: WORD_W];
		req_ch.word5        <= vert[5*WORD_W +: WORD_W];
		req_ch.corner_index <= corner;
		do @(posedge clk); while (!req_ch.ready);
		@(negedge clk);
		items_sent++;
		if (kind == REQ_VERTEX && mesh_verts < MAX_VERTS)
			mesh_verts++;
		else if (kind == REQ_CLEAR)
			mesh_verts = 0;
	endtask

	// Vertex pool; some entries differ from an earlier one in a single bit.
	task automatic make_pool(input int n);
		int i;
		pool_n = n;
		for (i = 0; i < n; i++) begin
			if (i > 0 && $urandom_range(0, 99) < 30)
				pool[i] = pool[$urandom_range(0, i - 1)] ^
					(VERT_W'(1) << $urandom_range(0, VERT_W - 1));
			else
				pool[i] = rand_vertex();
		end
	endtask

	task automatic send_corner();
		send_req(REQ_CORNER, rand_vertex(), pick_corner(mesh_verts));
	endtask

	// Small mesh: usually a clear, vertices from a pool, then triangles.
	task automatic run_mesh();
		int nverts;
		int i;
		if ($urandom_range(0, 99) < 85)
			send_req(REQ_CLEAR, rand_vertex(), $urandom);
		make_pool($urandom_range(1, 8));
		nverts = $urandom_range(1, 24);
		for (i = 0; i < nverts; i++) begin
			send_req(REQ_VERTEX, pool[$urandom_range(0, pool_n - 1)], $urandom);
			if ($urandom_range(0, 99) < 30)
				send_corner();
		end
		nverts = 3 * $urandom_range(1, 6);
		for (i = 0; i < nverts; i++)
			send_corner();
	endtask

	// Fills the store past capacity, with all vertices distinct or from a pool.
	task automatic run_fill(input bit all_distinct);
		logic [VERT_W-1:0] v;
		int                i;
		send_req(REQ_CLEAR, rand_vertex(), $urandom);
		make_pool($urandom_range(24, POOL_MAX));
		for (i = 0; i < MAX_VERTS + 4; i++) begin
			v = pool[$urandom_range(0, pool_n - 1)];
			if (all_distinct) begin
				v = rand_vertex();
				v[15:0] = 16'(i);
			end
			send_req(REQ_VERTEX, v, $urandom);
			if ($urandom_range(0, 99) < 8)
				send_corner();
		end
		send_req(REQ_CORNER, rand_vertex(), MAX_VERTS - 1);
		send_req(REQ_CORNER, rand_vertex(), MAX_VERTS);
		send_req(REQ_CORNER, rand_vertex(), 0);
		send_req(REQ_VERTEX, pool[0], $urandom);
	endtask

	// Noise: any code with random fields.
	task automatic run_noise();
		int n;
		int i;
		n = $urandom_range(1, 6);
		for (i = 0; i < n; i++)
			send_req(REQ_W'($urandom_range(0, 3)), rand_vertex(), pick_corner(mesh_verts));
	endtask

	// Stimulus and verdict.
	initial begin
		int phase;
		int phase_end;
		int sel;
		arst_n              = 1'b0;
		req_ch.valid        = 1'b0;
		req_ch.req_type     = REQ_VERTEX;
		req_ch.word0        = '0;
		req_ch.word1        = '0;
		req_ch.word2        = '0;
		req_ch.word3        = '0;
		req_ch.word4        = '0;
		req_ch.word5        = '0;
		req_ch.corner_index = '0;
		rsp_ch.ready        = 1'b0;
		items_sent          = 0;
		mesh_verts          = 0;
		pool_n              = 0;
		send_idle_pct       = 19;
		rsp_idle_pct        = 55;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Corners on an empty mesh are all out of range.
		send_req(REQ_CORNER, VERT_ZERO, 0);
		send_req(REQ_CORNER, VERT_ONES, -1);
		send_req(REQ_CORNER, VERT_ZERO, INDEX_MAX_POS);
		send_req(REQ_CORNER, VERT_ONES, INDEX_MIN_NEG);
		send_req(REQ_UNUSED, VERT_ONES, -1);
		// Duplicates weld onto the first copy; one flipped bit makes a new set.
		send_req(REQ_VERTEX, VERT_ZERO, 0);
		send_req(REQ_VERTEX, VERT_ONES, -1);
		send_req(REQ_VERTEX, VERT_ZERO, INDEX_MAX_POS);
		send_req(REQ_VERTEX, VERT_W'(1) << (VERT_W - 1), INDEX_MIN_NEG);
		send_req(REQ_VERTEX, VERT_ONES, 0);
		send_req(REQ_CORNER, VERT_ONES, 2);
		send_req(REQ_CORNER, VERT_ZERO, 4);
		send_req(REQ_CORNER, VERT_ONES, 5);
		send_req(REQ_UNUSED, VERT_ZERO, 0);
		// A clear empties the mesh; old entries must not be matched.
		send_req(REQ_CLEAR, VERT_ONES, -1);
		send_req(REQ_CORNER, VERT_ZERO, 0);
		send_req(REQ_VERTEX, VERT_ONES, 0);

		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 19;
					rsp_idle_pct  = 55;
				end
				1: begin
					send_idle_pct = 55;
					rsp_idle_pct  = 19;
				end
				default: begin
					send_idle_pct = 0;
					rsp_idle_pct  = 0;
				end
			endcase
			phase_end = items_sent + RANDOM_ITEMS / 3;
			if (phase == 0)
				run_fill(1'b1);
			else if (phase == 2)
				run_fill(1'b0);
			while (items_sent < phase_end) begin
				sel = $urandom_range(0, 99);
				if (sel < 1)
					run_fill(1'($urandom_range(0, 1)));
				else if (sel < 22)
					run_noise();
				else
					run_mesh();
			end
			// Hold off until every result of this phase has come back.
			req_ch.valid <= 1'b0;
			while (results_due != 0)
				@(negedge clk);
		end

		repeat (DRAIN_CYCLES) @(negedge clk);
		if (weld_errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
